@@ rtl/core/gn2d_pkg.sv @@
package gn2d_pkg;

  localparam int FRAC_BITS = 14;
  localparam int INT_BITS  = 10;
  localparam int COORD_W   = INT_BITS + FRAC_BITS;
  localparam int ENTRY_W   = 6;
  localparam int GRAD_W    = 16;
  localparam int HEIGHT_W  = 15;
  localparam int OUT_W     = 16;
  localparam int GRID_DEF  = 64;

  // internal datapath widths
  localparam int FSQ_W     = 2 * FRAC_BITS;       // f*f
  localparam int SMK_W     = FRAC_BITS + 2;       // 3*2^F - 2f
  localparam int SP_W      = FSQ_W + SMK_W;       // smoothstep product
  localparam int SW        = FRAC_BITS + 1;       // weight, 0..2^F
  localparam int DOT_W     = 32;
  localparam int DIFF_W    = DOT_W + 1;
  localparam int PROD_W    = DIFF_W + SW + 1;
  localparam int LERP_W    = DOT_W + 4;
  localparam int P2_W      = LERP_W + SW + 1;
  localparam int SMOOTH_K  = 3 << FRAC_BITS;

  typedef enum logic [1:0] {
    CMD_LOAD_GRAD   = 2'd0,
    CMD_LOAD_HEIGHT = 2'd1,
    CMD_NOISE_2D    = 2'd2,
    CMD_NOISE_1D    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } ctl_t;

endpackage

@@ rtl/core/gn2d_ram.sv @@
module gn2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/gn2d_fetch.sv @@
module gn2d_fetch #(
  parameter int GRID = gn2d_pkg::GRID_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [1:0]                          command,
  input  logic [gn2d_pkg::COORD_W-1:0]        coord_x,
  input  logic [gn2d_pkg::COORD_W-1:0]        coord_y,
  input  logic [gn2d_pkg::ENTRY_W-1:0]        entry_col,
  input  logic [gn2d_pkg::ENTRY_W-1:0]        entry_row,
  input  logic signed [gn2d_pkg::GRAD_W-1:0]  grad_x,
  input  logic signed [gn2d_pkg::GRAD_W-1:0]  grad_y,
  input  logic [gn2d_pkg::HEIGHT_W-1:0]       height_value,
  output gn2d_pkg::ctl_t                      ctl,
  output logic [gn2d_pkg::FRAC_BITS-1:0]      fx,
  output logic [gn2d_pkg::FRAC_BITS-1:0]      fy,
  output logic [gn2d_pkg::FSQ_W-1:0]          ffx,
  output logic [gn2d_pkg::FSQ_W-1:0]          ffy,
  output logic [2*gn2d_pkg::GRAD_W-1:0]       grad_c [4],
  output logic [gn2d_pkg::HEIGHT_W-1:0]       h0,
  output logic [gn2d_pkg::HEIGHT_W-1:0]       h1
);
  import gn2d_pkg::*;

  localparam int GB  = $clog2(GRID);
  localparam int HB  = (GB > 1) ? GB - 1 : 1;
  localparam int GAW = 2 * HB;

  logic [GB-1:0]  x0, x1, y0, y1, wcol, wrow;
  logic [GB-1:0]  col_sel [2];
  logic [GB-1:0]  row_sel [2];
  logic [GAW-1:0] gwaddr;
  logic [2*GRAD_W-1:0]   gdata [2][2];
  logic [HEIGHT_W-1:0]   hdata [2];
  logic           x0b, y0b;
  logic           accept;
  cmd_t           cmd_in;

  assign cmd_in = cmd_t'(command);
  assign accept = en && in_valid;

  assign x0 = GB'(coord_x >> FRAC_BITS);
  assign y0 = GB'(coord_y >> FRAC_BITS);
  assign x1 = x0 + GB'(1);
  assign y1 = y0 + GB'(1);

  // even/odd neighbor per axis; each of the four banks is read once
  assign col_sel[0] = x0[0] ? x1 : x0;
  assign col_sel[1] = x0[0] ? x0 : x1;
  assign row_sel[0] = y0[0] ? y1 : y0;
  assign row_sel[1] = y0[0] ? y0 : y1;

  assign wcol   = GB'(entry_col);
  assign wrow   = GB'(entry_row);
  assign gwaddr = {HB'(wrow >> 1), HB'(wcol >> 1)};

  for (genvar r = 0; r < 2; r++) begin : g_row
    for (genvar c = 0; c < 2; c++) begin : g_col
      gn2d_ram #(.WIDTH(2*GRAD_W), .DEPTH(1 << GAW)) u_grad (
        .clk   (clk),
        .we    (accept && cmd_in == CMD_LOAD_GRAD && wrow[0] == 1'(r) && wcol[0] == 1'(c)),
        .waddr (gwaddr),
        .wdata ({grad_y, grad_x}),
        .re    (en),
        .raddr ({HB'(row_sel[r] >> 1), HB'(col_sel[c] >> 1)}),
        .rdata (gdata[r][c])
      );
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_hgt
    gn2d_ram #(.WIDTH(HEIGHT_W), .DEPTH(1 << HB)) u_height (
      .clk   (clk),
      .we    (accept && cmd_in == CMD_LOAD_HEIGHT && wcol[0] == 1'(c)),
      .waddr (HB'(wcol >> 1)),
      .wdata (height_value),
      .re    (en),
      .raddr (HB'(col_sel[c] >> 1)),
      .rdata (hdata[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl.cmd <= cmd_in;
      fx      <= coord_x[FRAC_BITS-1:0];
      fy      <= coord_y[FRAC_BITS-1:0];
      ffx     <= FSQ_W'(coord_x[FRAC_BITS-1:0]) * FSQ_W'(coord_x[FRAC_BITS-1:0]);
      ffy     <= FSQ_W'(coord_y[FRAC_BITS-1:0]) * FSQ_W'(coord_y[FRAC_BITS-1:0]);
      x0b     <= x0[0];
      y0b     <= y0[0];
    end
  end

  // corners: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
  assign grad_c[0] = gdata[y0b][x0b];
  assign grad_c[1] = gdata[y0b][~x0b];
  assign grad_c[2] = gdata[~y0b][x0b];
  assign grad_c[3] = gdata[~y0b][~x0b];
  assign h0 = hdata[x0b];
  assign h1 = hdata[~x0b];

endmodule

@@ rtl/core/gn2d_blend.sv @@
module gn2d_blend (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  gn2d_pkg::ctl_t                    ctl_in,
  input  logic [gn2d_pkg::FRAC_BITS-1:0]    fx,
  input  logic [gn2d_pkg::FRAC_BITS-1:0]    fy,
  input  logic [gn2d_pkg::FSQ_W-1:0]        ffx,
  input  logic [gn2d_pkg::FSQ_W-1:0]        ffy,
  input  logic [2*gn2d_pkg::GRAD_W-1:0]     grad_c [4],
  input  logic [gn2d_pkg::HEIGHT_W-1:0]     h0,
  input  logic [gn2d_pkg::HEIGHT_W-1:0]     h1,
  output gn2d_pkg::ctl_t                    ctl_out,
  output logic signed [gn2d_pkg::OUT_W-1:0] res
);
  import gn2d_pkg::*;

  localparam logic [SP_W-1:0]          SP_HALF   = SP_W'(1) << (2*FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [P2_W-1:0]   P2_HALF   = P2_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [LERP_W-1:0] L_HALF    = LERP_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [LERP_W-1:0] S_MAX     = LERP_W'(32767);
  localparam logic signed [LERP_W-1:0] S_MIN     = -LERP_W'(32768);
  localparam logic signed [LERP_W-1:0] L_ZERO    = '0;
  localparam logic signed [FRAC_BITS:0] ONE_F    = (FRAC_BITS+1)'(1 << FRAC_BITS);

  ctl_t ctl2, ctl3, ctl4, ctl5, ctl6, ctl7;

  logic signed [FRAC_BITS:0] dx [2];
  logic signed [FRAC_BITS:0] dy [2];
  logic signed [DOT_W-1:0]   dot [4];
  logic [SMK_W-1:0]          kx, ky;
  logic                      is1d;

  // stage 2: corner dots, smoothstep products
  logic signed [DOT_W-1:0]   a_t2, b_t2, a_b2, b_b2;
  logic [SP_W-1:0]           px2, py2;
  // stage 3: weights, differences
  logic [SW-1:0]             sx3, sy3;
  logic signed [DIFF_W-1:0]  dt3, db3;
  logic signed [DOT_W-1:0]   a_t3, a_b3;
  // stage 4: x products
  logic signed [PROD_W-1:0]  pt4, pb4;
  logic signed [DOT_W-1:0]   a_t4, a_b4;
  logic [SW-1:0]             sy4;
  // stage 5: top and bottom rows
  logic signed [LERP_W-1:0]  top5, bot5;
  logic [SW-1:0]             sy5;
  // stage 6: y product
  logic signed [P2_W-1:0]    p26;
  logic signed [LERP_W-1:0]  top6;
  // stage 7: blended value
  logic signed [LERP_W-1:0]  v7, top7;
  logic signed [LERP_W-1:0]  r2d;

  assign dx[0] = signed'({1'b0, fx});
  assign dx[1] = signed'({1'b0, fx}) - ONE_F;
  assign dy[0] = signed'({1'b0, fy});
  assign dy[1] = signed'({1'b0, fy}) - ONE_F;

  for (genvar i = 0; i < 4; i++) begin : g_dot
    assign dot[i] =
      DOT_W'(dx[i % 2]) * DOT_W'(signed'(grad_c[i][GRAD_W-1:0])) +
      DOT_W'(dy[i / 2]) * DOT_W'(signed'(grad_c[i][2*GRAD_W-1:GRAD_W]));
  end

  assign kx   = SMK_W'(SMOOTH_K) - {1'b0, fx, 1'b0};
  assign ky   = SMK_W'(SMOOTH_K) - {1'b0, fy, 1'b0};
  assign is1d = (ctl_in.cmd == CMD_NOISE_1D);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2.valid    <= 1'b0;
      ctl3.valid    <= 1'b0;
      ctl4.valid    <= 1'b0;
      ctl5.valid    <= 1'b0;
      ctl6.valid    <= 1'b0;
      ctl7.valid    <= 1'b0;
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl2.valid    <= ctl_in.valid;
      ctl3.valid    <= ctl2.valid;
      ctl4.valid    <= ctl3.valid;
      ctl5.valid    <= ctl4.valid;
      ctl6.valid    <= ctl5.valid;
      ctl7.valid    <= ctl6.valid;
      ctl_out.valid <= ctl7.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl2.cmd    <= ctl_in.cmd;
      ctl3.cmd    <= ctl2.cmd;
      ctl4.cmd    <= ctl3.cmd;
      ctl5.cmd    <= ctl4.cmd;
      ctl6.cmd    <= ctl5.cmd;
      ctl7.cmd    <= ctl6.cmd;
      ctl_out.cmd <= ctl7.cmd;

      a_t2 <= is1d ? DOT_W'({1'b0, h0}) : dot[0];
      b_t2 <= is1d ? DOT_W'({1'b0, h1}) : dot[1];
      a_b2 <= dot[2];
      b_b2 <= dot[3];
      px2  <= SP_W'(ffx) * SP_W'(kx);
      py2  <= SP_W'(ffy) * SP_W'(ky);

      sx3  <= SW'((px2 + SP_HALF) >> (2*FRAC_BITS));
      sy3  <= SW'((py2 + SP_HALF) >> (2*FRAC_BITS));
      dt3  <= DIFF_W'(b_t2) - DIFF_W'(a_t2);
      db3  <= DIFF_W'(b_b2) - DIFF_W'(a_b2);
      a_t3 <= a_t2;
      a_b3 <= a_b2;

      pt4  <= PROD_W'(dt3) * PROD_W'(signed'({1'b0, sx3}));
      pb4  <= PROD_W'(db3) * PROD_W'(signed'({1'b0, sx3}));
      a_t4 <= a_t3;
      a_b4 <= a_b3;
      sy4  <= sy3;

      top5 <= LERP_W'(a_t4) + LERP_W'((pt4 + PROD_HALF) >>> FRAC_BITS);
      bot5 <= LERP_W'(a_b4) + LERP_W'((pb4 + PROD_HALF) >>> FRAC_BITS);
      sy5  <= sy4;

      p26  <= (P2_W'(bot5) - P2_W'(top5)) * P2_W'(signed'({1'b0, sy5}));
      top6 <= top5;

      v7   <= top6 + LERP_W'((p26 + P2_HALF) >>> FRAC_BITS);
      top7 <= top6;

      case (ctl7.cmd)
        CMD_NOISE_2D: begin
          res <= (r2d > S_MAX) ? OUT_W'(S_MAX) :
                 (r2d < S_MIN) ? OUT_W'(S_MIN) : OUT_W'(r2d);
        end
        CMD_NOISE_1D: begin
          res <= (top7 > S_MAX) ? OUT_W'(S_MAX) :
                 (top7 < L_ZERO) ? '0 : OUT_W'(top7);
        end
        default: begin
          res <= '0;
        end
      endcase
    end
  end

  assign r2d = (v7 + L_HALF) >>> FRAC_BITS;

endmodule

@@ rtl/core/gradient_noise_2d.sv @@
// 2D gradient (Perlin) noise with a 1D height-blend mode. Each transaction
// carries one command: load a gradient entry, load a height entry, evaluate
// 2D noise at (coord_x, coord_y), or blend two height entries at coord_x.
// Coordinates are unsigned Q10.14; grid indices wrap modulo GRID (a power of
// two). Every transaction returns exactly one noise_value: signed Q1.14 for
// 2D, 0..32767 for 1D, zero for loads. Tables power up undefined; read only
// entries that were loaded. Throughput is one transaction per cycle while the
// output skid register is empty. The gradient table is split into four banks
// by row and column parity so the four corners of a cell come from one read
// of each bank in the same cycle; the height table is split in two the same
// way. A load followed directly by an evaluate of the same entry sees the new
// value. Backpressure stalls the whole pipeline only once the output skid
// register is full, so in_ready is registered.
module gradient_noise_2d #(
  parameter int GRID = gn2d_pkg::GRID_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          command,
  input  logic [gn2d_pkg::COORD_W-1:0]        coord_x,
  input  logic [gn2d_pkg::COORD_W-1:0]        coord_y,
  input  logic [gn2d_pkg::ENTRY_W-1:0]        entry_col,
  input  logic [gn2d_pkg::ENTRY_W-1:0]        entry_row,
  input  logic signed [gn2d_pkg::GRAD_W-1:0]  grad_x,
  input  logic signed [gn2d_pkg::GRAD_W-1:0]  grad_y,
  input  logic [gn2d_pkg::HEIGHT_W-1:0]       height_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [gn2d_pkg::OUT_W-1:0]   noise_value
);
  import gn2d_pkg::*;

  logic                     en;
  ctl_t                     ctl1, ctl_res;
  logic [FRAC_BITS-1:0]     fx, fy;
  logic [FSQ_W-1:0]         ffx, ffy;
  logic [2*GRAD_W-1:0]      grad_c [4];
  logic [HEIGHT_W-1:0]      h0, h1;
  logic signed [OUT_W-1:0]  res;
  logic                     skid_valid;
  logic signed [OUT_W-1:0]  skid_data;

  // pipeline moves whenever the skid slot is free
  assign en       = !skid_valid;
  assign in_ready = en;

  gn2d_fetch #(.GRID(GRID)) u_fetch (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (in_valid),
    .command      (command),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .entry_col    (entry_col),
    .entry_row    (entry_row),
    .grad_x       (grad_x),
    .grad_y       (grad_y),
    .height_value (height_value),
    .ctl          (ctl1),
    .fx           (fx),
    .fy           (fy),
    .ffx          (ffx),
    .ffy          (ffy),
    .grad_c       (grad_c),
    .h0           (h0),
    .h1           (h1)
  );

  gn2d_blend u_blend (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl1),
    .fx      (fx),
    .fy      (fy),
    .ffx     (ffx),
    .ffy     (ffy),
    .grad_c  (grad_c),
    .h0      (h0),
    .h1      (h1),
    .ctl_out (ctl_res),
    .res     (res)
  );

  // output register plus one skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        noise_value <= skid_data;
        skid_valid  <= 1'b0;
      end
    end else if (ctl_res.valid) begin
      if (out_valid && !out_ready) begin
        skid_data  <= res;
        skid_valid <= 1'b1;
      end else begin
        noise_value <= res;
        out_valid   <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds data while output is empty");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ready |=> out_valid && !skid_valid)
    else $error("skid did not drain into output");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !skid_valid)
    else $error("output not cleared by reset");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    ctl_res.valid && en && out_valid && !out_ready |=> skid_valid)
    else $error("result lost under backpressure");
`endif

endmodule
